// File: hw/rtl/aesdu_pkg.sv
// ----------------------------------------------------------------------------
// AES decrypt/unpad package
// Shared constants, S-box tables and GF(2^8) helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package aesdu_pkg;
   localparam int BlockBytes = 16;
   localparam int CountW = 5;
   localparam int RoundW = 4;

   localparam logic [2:0] CSR_KEY0 = 3'd0;
   localparam logic [2:0] CSR_KEY1 = 3'd1;
   localparam logic [2:0] CSR_KEY2 = 3'd2;
   localparam logic [2:0] CSR_KEY3 = 3'd3;
   localparam logic [2:0] CSR_KLEN = 3'd4;
   localparam logic [2:0] CSR_PAD  = 3'd5;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // load held block into state, add last round key
      logic round;     // one middle inverse round
      logic last;      // final inverse round
      logic kinit;     // load key words for expansion
      logic kstep;     // compute one expansion word
   } dp_cmd_type;

   typedef struct packed {
      logic kdone;
   } dp_sts_type;

   function automatic logic [7:0] xt(input logic [7:0] a);
      xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
      logic [7:0] a2, a4, a8, p;
      a2 = xt(a);
      a4 = xt(a2);
      a8 = xt(a4);
      p = 8'h00;
      if (b[0]) p = p ^ a;
      if (b[1]) p = p ^ a2;
      if (b[2]) p = p ^ a4;
      if (b[3]) p = p ^ a8;
      gm = p;
   endfunction

   function automatic logic [7:0] gmf(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] p, x;
      p = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) p = p ^ x;
         x = xt(x);
      end
      gmf = p;
   endfunction

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] inv, s;
      logic [7:0] sq;
      inv = 8'h00;
      sq = x;
      // x^254 by square and multiply: exponent bits 11111110
      if (x != 8'h00) begin
         inv = 8'h01;
         for (int k = 1; k < 8; k++) begin
            sq = gmf(sq, sq);
            inv = gmf(inv, sq);
         end
      end
      s = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      sbox = s;
   endfunction

   typedef logic [7:0] sbox_arr_type [256];

   function automatic sbox_arr_type mk_fwd();
      sbox_arr_type t;
      for (int i = 0; i < 256; i++) t[i] = sbox(8'(i));
      mk_fwd = t;
   endfunction

   function automatic sbox_arr_type mk_inv();
      sbox_arr_type t;
      for (int i = 0; i < 256; i++) t[sbox(8'(i))] = 8'(i);
      mk_inv = t;
   endfunction

   localparam sbox_arr_type FwdSbox = mk_fwd();
   localparam sbox_arr_type InvSbox = mk_inv();
endpackage
`default_nettype wire

// File: hw/rtl/aesdu_datapath.sv
// ----------------------------------------------------------------------------
// AES decrypt datapath
// Key expansion (one word per cycle), round key store, inverse round unit.
// ----------------------------------------------------------------------------
`default_nettype none
module aesdu_datapath import aesdu_pkg::*; (
   input  wire logic          clock,
   input  wire logic [255:0]  key,
   input  wire logic [1:0]    klen,
   input  wire logic [127:0]  blk,
   input  wire logic [RoundW-1:0] rnd,
   input  wire dp_cmd_type    cmd,
   output dp_sts_type         sts,
   output logic [127:0]       state
);
   logic [31:0] w_ff [8];
   logic [31:0] w_in [8];
   logic [5:0]  wi_ff, wi_in;
   logic [2:0]  wm_ff, wm_in;
   logic [7:0]  rc_ff, rc_in;
   logic [127:0] rk_mem [15];
   logic [127:0] rk_q;
   logic [127:0] st_ff, st_in;
   logic [3:0]  nk;
   logic [2:0]  top_i;
   logic [5:0]  total;
   logic [31:0] t, wn;

   always_comb begin
      nk = (klen == 2'd0) ? 4'd4 : (klen == 2'd1) ? 4'd6 : 4'd8;
      top_i = 3'(nk - 4'd1);
      total = 6'(4 * (nk + 7));
   end
   assign sts.kdone = (wi_ff >= total);

   // Expansion: w_ff is a sliding window of the last nk words (index 0 oldest).
   always_comb begin
      t = w_ff[top_i];
      if (wm_ff == 3'd0) begin
         t = {t[23:0], t[31:24]};
         t = {FwdSbox[t[31:24]], FwdSbox[t[23:16]], FwdSbox[t[15:8]], FwdSbox[t[7:0]]}
             ^ {rc_ff, 24'h0};
      end else if (nk == 4'd8 && wm_ff == 3'd4) begin
         t = {FwdSbox[t[31:24]], FwdSbox[t[23:16]], FwdSbox[t[15:8]], FwdSbox[t[7:0]]};
      end
      wn = w_ff[0] ^ t;
      w_in = w_ff;
      wi_in = wi_ff;
      wm_in = wm_ff;
      rc_in = rc_ff;
      if (cmd.kinit) begin
         for (int i = 0; i < 8; i++) w_in[i] = key[255-32*i -: 32];
         wi_in = 6'(nk);
         wm_in = 3'd0;
         rc_in = 8'h01;
      end else if (cmd.kstep && !sts.kdone) begin
         for (int i = 0; i < 7; i++) w_in[i] = w_ff[i+1];
         w_in[top_i] = wn;
         wi_in = wi_ff + 6'd1;
         wm_in = (wm_ff == top_i) ? 3'd0 : wm_ff + 3'd1;
         if (wm_ff == 3'd0) rc_in = xt(rc_ff);
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      wi_ff <= wi_in;
      wm_ff <= wm_in;
      rc_ff <= rc_in;
   end

   // Round key store: words written as four-byte slices into a row.
   // A 192-bit key starts expanding at word 6, so row 1 begins with key
   // words 4 and 5; for the other lengths the preload is overwritten.
   logic [127:0] row_ff, row_in;
   always_comb begin
      row_in = row_ff;
      if (cmd.kinit) row_in = {key[127:64], 64'h0};
      else if (cmd.kstep && !sts.kdone)
         row_in[127 - 32*wi_ff[1:0] -: 32] = wn;
   end
   always_ff @(posedge clock) begin
      row_ff <= row_in;
      if (cmd.kinit) begin
         // Initial key words form the first one or two rows.
         rk_mem[0] <= key[255:128];
         if (nk == 4'd8) rk_mem[1] <= key[127:0];
      end else if (cmd.kstep && !sts.kdone && wi_ff[1:0] == 2'd3) begin
         rk_mem[wi_ff[5:2]] <= row_in;
      end
      rk_q <= rk_mem[rnd];
   end

   function automatic logic [127:0] inv_ss(input logic [127:0] s);
      logic [127:0] o;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++)
            o[127 - 8*(r + 4*c) -: 8] = InvSbox[s[127 - 8*(r + 4*((c + 4 - r) % 4)) -: 8]];
      inv_ss = o;
   endfunction

   function automatic logic [127:0] inv_mx(input logic [127:0] s);
      logic [127:0] o;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = s[127-32*c -: 8];
         a1 = s[119-32*c -: 8];
         a2 = s[111-32*c -: 8];
         a3 = s[103-32*c -: 8];
         o[127-32*c -: 8] = gm(a0,4'd14)^gm(a1,4'd11)^gm(a2,4'd13)^gm(a3,4'd9);
         o[119-32*c -: 8] = gm(a0,4'd9)^gm(a1,4'd14)^gm(a2,4'd11)^gm(a3,4'd13);
         o[111-32*c -: 8] = gm(a0,4'd13)^gm(a1,4'd9)^gm(a2,4'd14)^gm(a3,4'd11);
         o[103-32*c -: 8] = gm(a0,4'd11)^gm(a1,4'd13)^gm(a2,4'd9)^gm(a3,4'd14);
      end
      inv_mx = o;
   endfunction

   always_comb begin
      st_in = st_ff;
      if (cmd.load) st_in = blk ^ rk_q;
      else if (cmd.round) st_in = inv_mx(inv_ss(st_ff) ^ rk_q);
      else if (cmd.last) st_in = inv_ss(st_ff) ^ rk_q;
   end
   always_ff @(posedge clock) st_ff <= st_in;
   assign state = st_ff;
endmodule
`default_nettype wire

// File: hw/rtl/aesdu_ctrl.sv
// ----------------------------------------------------------------------------
// AES decrypt controller
// Sequences key expansion and the inverse rounds of one block.
// ----------------------------------------------------------------------------
`default_nettype none
module aesdu_ctrl import aesdu_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          kreq,
   input  wire logic          start,
   input  wire logic [1:0]    klen,
   input  wire dp_sts_type    sts,
   output dp_cmd_type         cmd,
   output logic [RoundW-1:0]  rnd,
   output logic               busy,
   output logic               done
);
   typedef enum logic [2:0] {S_KINIT, S_KEXP, S_IDLE, S_FETCH, S_LOAD, S_RUN, S_DONE}
      st_type;
   st_type st_ff, st_in;
   logic [RoundW-1:0] r_ff, r_in;
   logic [RoundW-1:0] nr;

   assign nr = (klen == 2'd0) ? 4'd10 : (klen == 2'd1) ? 4'd12 : 4'd14;

   always_comb begin
      st_in = st_ff;
      r_in = r_ff;
      cmd = '0;
      case (st_ff)
         S_KINIT: begin
            cmd.kinit = 1'b1;
            st_in = S_KEXP;
         end
         S_KEXP: begin
            cmd.kstep = 1'b1;
            if (sts.kdone) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (kreq) st_in = S_KINIT;
            else if (start) begin
               r_in = nr;
               st_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            r_in = r_ff - 4'd1;
            st_in = S_RUN;
         end
         S_RUN: begin
            if (r_ff == 4'd0) begin
               cmd.last = 1'b1;
               st_in = S_DONE;
            end else begin
               cmd.round = 1'b1;
               r_in = r_ff - 4'd1;
            end
         end
         S_DONE: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_KINIT;
         r_ff <= '0;
      end else begin
         st_ff <= st_in;
         r_ff <= r_in;
      end
   end

   // Round key read is registered, so address the key for the next step.
   assign rnd = r_in;
   assign busy = (st_ff != S_IDLE) || kreq;
   assign done = (st_ff == S_DONE);
endmodule
`default_nettype wire

// File: hw/rtl/aes_ecb_decrypt_unpad_stream_unit.sv
// ----------------------------------------------------------------------------
// AES-ECB decrypt stream with PKCS unpad
// Top level: registers, input hold stage, controller, datapath, output stage.
// ----------------------------------------------------------------------------
// Usage: req_ beats carry a 16-byte ciphertext block with a byte count, or an
// end-of-stream marker (req_func = 1). Each block is held back one beat; a data
// beat releases the previously held block decrypted on the rsp_ channel, an
// end beat releases it as the final block with PKCS padding stripped, or, with
// padding mode off, as an empty final beat with rsp_error_flag set.
// A block passes through a load step (the first key add) and 10/12/14
// inverse rounds in the single shared round unit, then into the output
// register; the next req_ beat is taken only after the result is stored.
// The csr_ port writes key words, key length and padding mode; each write
// to indices 0 to 5 starts a key expansion (40 to 52 key words, one per
// cycle), during which req_ is stalled. After reset the all-zero 128-bit key
// is expanded the same way before the first beat is taken. The output
// register holds its beat while rsp_stall is high; a new req_ beat may still
// be taken, but the decryption it releases does not start until the register
// is free.
`default_nettype none
module aes_ecb_decrypt_unpad_stream_unit import aesdu_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_func,
   input  wire logic [63:0] req_block_high,
   input  wire logic [63:0] req_block_low,
   input  wire logic [4:0]  req_valid_bytes,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_plain_high,
   output logic [63:0]      rsp_plain_low,
   output logic [4:0]       rsp_out_bytes,
   output logic             rsp_final_block,
   output logic             rsp_error_flag,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   logic [255:0] key_ff;
   logic [1:0]   klen_ff;
   logic         pad_ff;
   logic         kreq_ff;
   logic [127:0] held_ff;
   logic         held_v_ff;
   logic         pend_ff;      // decryption pending or running for a released block
   logic         pend_fin_ff;
   logic         rv_ff;
   logic [63:0]  ph_ff, pl_ff;
   logic [4:0]   ob_ff;
   logic         fb_ff, ef_ff;
   logic [127:0] nblk_ff;
   logic         nblk_v_ff;
   dp_cmd_type   cmd;
   dp_sts_type   sts;
   logic [RoundW-1:0] rnd;
   logic         busy, done, start;
   logic [127:0] state;
   logic         acc, cacc;
   logic [127:0] cblk;
   logic [127:0] masked;
   logic [4:0]   n;
   logic [7:0]   padb;

   assign csr_ready = 1'b1;
   assign cacc = csr_valid && csr_ready;
   // Accept an input only when no block is pending and the datapath is free.
   assign req_stall = pend_ff || nblk_v_ff || busy || kreq_ff || cacc;
   assign acc = req_valid && !req_stall;

   assign cblk = {req_block_high, req_block_low};
   always_comb begin
      n = (req_valid_bytes > 5'd16) ? 5'd16 : req_valid_bytes;
      for (int i = 0; i < 16; i++)
         masked[127-8*i -: 8] = (5'(i) < n) ? cblk[127-8*i -: 8] : 8'h00;
   end

   // A decryption starts only with the output register empty, so its result
   // can always be stored in the single cycle the controller reports done.
   assign start = pend_ff && !busy && !done && !rv_ff;

   aesdu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .kreq(kreq_ff), .start(start), .klen(klen_ff),
      .sts(sts), .cmd(cmd), .rnd(rnd), .busy(busy), .done(done)
   );

   aesdu_datapath u_dp (
      .clock(clock), .key(key_ff), .klen(klen_ff), .blk(held_ff), .rnd(rnd),
      .cmd(cmd), .sts(sts), .state(state)
   );

   logic run_ff;
   assign padb = state[7:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         klen_ff <= 2'd0;
         pad_ff <= 1'b1;
         kreq_ff <= 1'b0;
         held_v_ff <= 1'b0;
         pend_ff <= 1'b0;
         run_ff <= 1'b0;
         rv_ff <= 1'b0;
         nblk_v_ff <= 1'b0;
         held_ff <= '0;
      end else begin
         if (cacc) begin
            case (csr_index)
               CSR_KEY0: key_ff[255:192] <= csr_data;
               CSR_KEY1: key_ff[191:128] <= csr_data;
               CSR_KEY2: key_ff[127:64]  <= csr_data;
               CSR_KEY3: key_ff[63:0]    <= csr_data;
               CSR_KLEN: klen_ff <= csr_data[1:0];
               CSR_PAD:  pad_ff <= csr_data[0];
               default: ;
            endcase
            if (csr_index <= CSR_PAD) kreq_ff <= 1'b1;
         end else if (cmd.kinit) begin
            // The request stands until the controller actually loads the key.
            kreq_ff <= 1'b0;
         end
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (acc) begin
            if (req_func) begin
               if (held_v_ff) begin
                  pend_ff <= 1'b1;
                  pend_fin_ff <= 1'b1;
                  held_v_ff <= 1'b0;
               end
            end else if (held_v_ff) begin
               pend_ff <= 1'b1;
               pend_fin_ff <= 1'b0;
               nblk_ff <= masked;
               nblk_v_ff <= 1'b1;
            end else begin
               held_ff <= masked;
               held_v_ff <= 1'b1;
            end
         end
         if (start) run_ff <= 1'b1;
         if (done && run_ff) begin
            run_ff <= 1'b0;
            pend_ff <= 1'b0;
            rv_ff <= 1'b1;
            fb_ff <= pend_fin_ff;
            if (pend_fin_ff && !pad_ff) begin
               ph_ff <= '0; pl_ff <= '0; ob_ff <= 5'd0; ef_ff <= 1'b1;
            end else begin
               ph_ff <= state[127:64];
               pl_ff <= state[63:0];
               ef_ff <= 1'b0;
               ob_ff <= (pend_fin_ff && padb <= 8'd16) ? 5'(8'd16 - padb) : 5'd16;
            end
            if (nblk_v_ff) begin
               held_ff <= nblk_ff;
               nblk_v_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_plain_high = ph_ff;
   assign rsp_plain_low = pl_ff;
   assign rsp_out_bytes = ob_ff;
   assign rsp_final_block = fb_ff;
   assign rsp_error_flag = ef_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_out_bytes == 5'd0 && rsp_final_block)
      else $error("error beat not final or nonzero length");
   a_no_acc_busy: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> req_stall)
      else $error("input taken while block pending");
   a_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_block |-> rsp_out_bytes == 5'd16)
      else $error("data beat not full");
endmodule
`default_nettype wire
